/* rtl/kmc_pkg.sv */
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types, constants and codes of the keypad menu controller.
// ----------------------------------------------------------------------------
package kmc_pkg;

    // Sizing
    localparam int QUEUE_SIZE      = 8;
    localparam int PROGRAM_ENTRIES = 4;
    localparam int KEY_COUNT       = 3;

    // Event queue holds one less than its nominal size
    localparam int FIFO_DEPTH = QUEUE_SIZE - 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int EIDX_W     = (PROGRAM_ENTRIES > 1) ? $clog2(PROGRAM_ENTRIES) : 1;

    localparam logic [CNT_W-1:0]  FIFO_FULL   = CNT_W'(FIFO_DEPTH);
    localparam logic [EIDX_W:0]   ENTRY_LIMIT = (EIDX_W + 1)'(PROGRAM_ENTRIES);

    // Arithmetic constants
    localparam logic [11:0] DAY_MINUTES = 12'd1440;
    localparam logic [10:0] STEP_HOUR   = 11'd60;
    localparam logic [10:0] STEP_MINUTE = 11'd1;
    localparam logic [10:0] STEP_TENMIN = 11'd10;
    localparam logic [15:0] SP_STEP     = 16'd5;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_HOLD_TIMEOUT = 1'b0;
    localparam logic REG_SP_INITIAL   = 1'b1;
    localparam logic [15:0] HOLD_TIMEOUT_RESET = 16'd50;
    localparam logic [15:0] SP_INITIAL_RESET   = 16'd0;

    // Key codes
    localparam logic [1:0] KEY_UP   = 2'd0;
    localparam logic [1:0] KEY_DOWN = 2'd1;
    localparam logic [1:0] KEY_MENU = 2'd2;

    // Program entry field codes
    localparam logic [1:0] FIELD_TEMP   = 2'd0;
    localparam logic [1:0] FIELD_HOUR   = 2'd1;
    localparam logic [1:0] FIELD_TENMIN = 2'd2;
    localparam logic [1:0] FIELD_LAST   = 2'd2;

    typedef enum logic [2:0] {
        MODE_SP    = 3'd0,
        MODE_HOUR  = 3'd1,
        MODE_MIN   = 3'd2,
        MODE_PROG  = 3'd3,
        MODE_ONOFF = 3'd4
    } t_mode;

    // Input beat: one tick of key levels
    typedef struct packed {
        logic key_up;
        logic key_down;
        logic key_menu;
    } t_item;

    // Result beat
    typedef struct packed {
        logic [2:0]         menu_mode;
        logic signed [15:0] setpoint;
        logic [10:0]        time_offset;
        logic               control_on;
        logic [1:0]         entry_index;
        logic [1:0]         entry_field;
        logic signed [15:0] entry_temp;
        logic [10:0]        entry_minutes;
        logic               event_valid;
        logic               event_held;
        logic [1:0]         event_key;
        logic               program_saved;
    } t_result;

    // Queued key event
    typedef struct packed {
        logic       held;
        logic [1:0] key;
    } t_fifo_ent;

    // Per-tick token from front to back
    typedef struct packed {
        logic       valid;
        logic       held;
        logic [1:0] key;
    } t_event;

    // Setpoint load request from the configuration port
    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } t_sp_load;

endpackage

/* rtl/kmc_front.sv */
// ----------------------------------------------------------------------------
// kmc_front
// Key counters and drop-on-full event queue; emits one event token per tick.
// ----------------------------------------------------------------------------
module kmc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  kmc_pkg::t_item   i_item,
    input  logic [15:0]      i_hold_timeout,
    output kmc_pkg::t_event  o_event
);
    import kmc_pkg::*;

    logic [15:0]      r_ctr  [KEY_COUNT];
    logic [15:0]      n_ctr  [KEY_COUNT];
    t_fifo_ent        r_fifo [FIFO_DEPTH];
    t_fifo_ent        n_fifo [FIFO_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [KEY_COUNT-1:0] keys;
    logic             stop;
    logic [15:0]      cval;

    assign keys = {i_item.key_menu, i_item.key_down, i_item.key_up};

    // Count keys, queue press and held events, pop one event
    always_comb begin
        n_ctr   = r_ctr;
        n_fifo  = r_fifo;
        n_count = r_count;
        stop    = 1'b0;
        cval    = '0;
        o_event = '0;
        if (i_accept) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (!stop) begin
                    cval     = keys[k] ? r_ctr[k] + 16'd1 : 16'd0;
                    n_ctr[k] = cval;
                    if (cval == 16'd1) begin
                        if (n_count >= FIFO_FULL) begin
                            stop = 1'b1;
                        end else begin
                            n_fifo[n_count[IDX_W-1:0]] = '{held: 1'b0, key: 2'(k)};
                            n_count = n_count + CNT_W'(1);
                        end
                    end
                    if (!stop && (cval > i_hold_timeout)) begin
                        n_ctr[k] = 16'd1;
                        if (n_count >= FIFO_FULL) begin
                            stop = 1'b1;
                        end else begin
                            n_fifo[n_count[IDX_W-1:0]] = '{held: 1'b1, key: 2'(k)};
                            n_count = n_count + CNT_W'(1);
                        end
                    end
                end
            end
            // Pop the oldest event and shift the rest down
            if (n_count != '0) begin
                o_event = '{valid: 1'b1, held: n_fifo[0].held, key: n_fifo[0].key};
                for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
                    n_fifo[i] = n_fifo[i + 1];
                end
                n_count = n_count - CNT_W'(1);
            end
        end
    end

    // Hold counters and queue fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_ctr[k] <= '0;
            end
            r_count <= '0;
        end else begin
            r_ctr   <= n_ctr;
            r_count <= n_count;
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        r_fifo <= n_fifo;
    end

endmodule

/* rtl/kmc_link.sv */
// ----------------------------------------------------------------------------
// kmc_link
// Two-entry token queue between front and back.
// ----------------------------------------------------------------------------
module kmc_link (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kmc_pkg::t_event  i_event,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output kmc_pkg::t_event  o_event
);
    import kmc_pkg::*;

    t_event     r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_event = r_buf[r_rd];

    // Advance pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Hold beat payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_event;
        end
    end

endmodule

/* rtl/kmc_back.sv */
// ----------------------------------------------------------------------------
// kmc_back
// Menu state machine: dispatches event tokens and queues result beats.
// ----------------------------------------------------------------------------
module kmc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmc_pkg::t_sp_load i_sp_load,
    input  logic              i_link_empty,
    input  kmc_pkg::t_event   i_event,
    output logic              o_take,
    input  logic              i_pop,
    output logic              o_empty,
    output kmc_pkg::t_result  o_result
);
    import kmc_pkg::*;

    // Add or subtract a step on minutes of the day, wrapping
    function automatic logic [10:0] day_step(logic [10:0] m, logic [10:0] step, logic up);
        logic [11:0] s;
        if (up) begin
            s = {1'b0, m} + {1'b0, step};
            if (s >= DAY_MINUTES) begin
                s = s - DAY_MINUTES;
            end
        end else if (m < step) begin
            s = {1'b0, m} + DAY_MINUTES - {1'b0, step};
        end else begin
            s = {1'b0, m} - {1'b0, step};
        end
        return s[10:0];
    endfunction

    t_mode             r_mode, n_mode;
    logic [15:0]       r_setpoint, n_setpoint;
    logic [10:0]       r_offset, n_offset;
    logic              r_control, n_control;
    logic [EIDX_W-1:0] r_index, n_index;
    logic [1:0]        r_field, n_field;
    logic [15:0]       r_temps [PROGRAM_ENTRIES];
    logic [15:0]       n_temps [PROGRAM_ENTRIES];
    logic [10:0]       r_mins  [PROGRAM_ENTRIES];
    logic [10:0]       n_mins  [PROGRAM_ENTRIES];
    logic              saved;
    logic              is_up;
    logic              is_down;
    logic              is_menu;
    logic [10:0]       step;
    logic [EIDX_W:0]   idx_inc;
    t_result           result;

    t_result           r_out [2];
    logic              r_out_wr;
    logic              r_out_rd;
    logic [1:0]        r_out_cnt;
    logic              out_pop;

    assign o_take   = !i_link_empty && (r_out_cnt != 2'd2);
    assign o_empty  = (r_out_cnt == 2'd0);
    assign o_result = r_out[r_out_rd];
    assign out_pop  = i_pop && !o_empty;
    assign is_up    = (i_event.key == KEY_UP);
    assign is_down  = (i_event.key == KEY_DOWN);
    assign is_menu  = (i_event.key == KEY_MENU);

    // Dispatch the event against the current mode
    always_comb begin
        n_mode     = r_mode;
        n_setpoint = r_setpoint;
        n_offset   = r_offset;
        n_control  = r_control;
        n_index    = r_index;
        n_field    = r_field;
        n_temps    = r_temps;
        n_mins     = r_mins;
        saved      = 1'b0;
        step       = (r_mode == MODE_HOUR) ? STEP_HOUR : STEP_MINUTE;
        idx_inc    = {1'b0, r_index} + (EIDX_W + 1)'(1);
        if (o_take && i_event.valid) begin
            case (r_mode)
                MODE_SP: begin
                    if (is_up) begin
                        n_setpoint = r_setpoint + SP_STEP;
                    end else if (is_down) begin
                        n_setpoint = r_setpoint - SP_STEP;
                    end else if (is_menu && !i_event.held) begin
                        n_mode = MODE_HOUR;
                    end
                end
                MODE_HOUR, MODE_MIN: begin
                    if (is_up || is_down) begin
                        n_offset = day_step(r_offset, step, is_up);
                    end else if (is_menu && !i_event.held) begin
                        n_mode = (r_mode == MODE_HOUR) ? MODE_MIN : MODE_PROG;
                    end
                end
                MODE_PROG: begin
                    if (is_up || is_down) begin
                        case (r_field)
                            FIELD_TEMP: begin
                                n_temps[r_index] = is_up ? r_temps[r_index] + SP_STEP
                                                         : r_temps[r_index] - SP_STEP;
                            end
                            FIELD_HOUR: begin
                                n_mins[r_index] = day_step(r_mins[r_index], STEP_HOUR, is_up);
                            end
                            FIELD_TENMIN: begin
                                n_mins[r_index] = day_step(r_mins[r_index], STEP_TENMIN,
                                                           is_up);
                            end
                            default: begin
                            end
                        endcase
                    end else if (is_menu) begin
                        if (i_event.held) begin
                            n_index = '0;
                            n_field = FIELD_TEMP;
                            n_mode  = MODE_SP;
                            saved   = 1'b1;
                        end else if (r_field >= FIELD_LAST) begin
                            n_field = FIELD_TEMP;
                            if (idx_inc >= ENTRY_LIMIT) begin
                                n_index = '0;
                                n_mode  = MODE_ONOFF;
                                saved   = 1'b1;
                            end else begin
                                n_index = idx_inc[EIDX_W-1:0];
                            end
                        end else begin
                            n_field = r_field + 2'd1;
                        end
                    end
                end
                MODE_ONOFF: begin
                    if (!i_event.held) begin
                        if (is_up) begin
                            n_control = 1'b1;
                        end else if (is_down) begin
                            n_control = 1'b0;
                        end else if (is_menu) begin
                            n_mode = MODE_SP;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Build the result beat from the updated state
    always_comb begin
        result.menu_mode     = n_mode;
        result.setpoint      = n_setpoint;
        result.time_offset   = n_offset;
        result.control_on    = n_control;
        result.entry_index   = 2'(n_index);
        result.entry_field   = n_field;
        result.entry_temp    = n_temps[n_index];
        result.entry_minutes = n_mins[n_index];
        result.event_valid   = i_event.valid;
        result.event_held    = i_event.held;
        result.event_key     = i_event.key;
        result.program_saved = saved;
    end

    // Hold menu state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_SP;
            r_setpoint <= SP_INITIAL_RESET;
            r_offset   <= '0;
            r_control  <= 1'b1;
            r_index    <= '0;
            r_field    <= FIELD_TEMP;
            for (int i = 0; i < PROGRAM_ENTRIES; i++) begin
                r_temps[i] <= '0;
                r_mins[i]  <= '0;
            end
        end else begin
            r_mode     <= n_mode;
            r_setpoint <= i_sp_load.load ? i_sp_load.value : n_setpoint;
            r_offset   <= n_offset;
            r_control  <= n_control;
            r_index    <= n_index;
            r_field    <= n_field;
            r_temps    <= n_temps;
            r_mins     <= n_mins;
        end
    end

    // Advance result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr  <= 1'b0;
            r_out_rd  <= 1'b0;
            r_out_cnt <= 2'd0;
        end else begin
            if (o_take) begin
                r_out_wr <= ~r_out_wr;
            end
            if (out_pop) begin
                r_out_rd <= ~r_out_rd;
            end
            r_out_cnt <= r_out_cnt + {1'b0, o_take} - {1'b0, out_pop};
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out[r_out_wr] <= result;
        end
    end

endmodule

/* rtl/keypad_menu_controller_top.sv */
// ----------------------------------------------------------------------------
// keypad_menu_controller_top
// Three-key front-panel menu controller with register port.
// ----------------------------------------------------------------------------
// One input beat is one key sampling tick and gives exactly one result beat.
// The block takes one tick per clock cycle while full is low. Each tick waits in
// the token queue, then the menu logic writes its result beat into the result
// queue for pop. The front updates the key counters and the event queue and
// pops at most one event per tick. A two-entry token queue feeds the menu
// logic, which dispatches one event per cycle, while the result queue has room,
// into a two-entry result queue. When pop stays low, both queues fill and full
// rises. Write hold_timeout at 0x0 and setpoint_initial at 0x4 only while no
// tick is in flight; a setpoint_initial write also loads the current setpoint.
module keypad_menu_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Tick input
    input  logic                          push,
    output logic                          full,
    input  kmc_pkg::t_item                i_item,
    // Result output
    output logic                          empty,
    input  logic                          pop,
    output kmc_pkg::t_result              o_result,
    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmc_pkg::ADDR_W-1:0]    paddr,
    input  logic [kmc_pkg::DATA_W-1:0]    pwdata,
    output logic [kmc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import kmc_pkg::*;

    logic [15:0] r_hold_timeout;
    logic [15:0] r_sp_initial;
    logic        wr_en;
    logic        accept;
    t_sp_load    sp_load;
    t_event      front_event;
    t_event      link_event;
    logic        link_empty;
    logic        link_full;
    logic        back_take;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign accept = push && !full;
    assign full   = link_full;

    assign sp_load.load  = wr_en && (paddr[2] == REG_SP_INITIAL);
    assign sp_load.value = pwdata[15:0];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_timeout <= HOLD_TIMEOUT_RESET;
            r_sp_initial   <= SP_INITIAL_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_HOLD_TIMEOUT: r_hold_timeout <= pwdata[15:0];
                REG_SP_INITIAL:   r_sp_initial   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[2])
            REG_HOLD_TIMEOUT: prdata = {{(DATA_W - 16){1'b0}}, r_hold_timeout};
            REG_SP_INITIAL:   prdata = {{(DATA_W - 16){1'b0}}, r_sp_initial};
            default:          prdata = '0;
        endcase
    end

    kmc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_item         (i_item),
        .i_hold_timeout (r_hold_timeout),
        .o_event        (front_event)
    );

    kmc_link u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_event (front_event),
        .o_full  (link_full),
        .i_pop   (back_take),
        .o_empty (link_empty),
        .o_event (link_event)
    );

    kmc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sp_load    (sp_load),
        .i_link_empty (link_empty),
        .i_event      (link_event),
        .o_take       (back_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad menu controller. Key level ticks go in
// through the push side, one result beat per tick comes back on the pop side,
// and each beat is checked field by field against a cycle-free panel model
// kept here. A short directed table opens the run, then random key gestures
// (taps, long holds, chords, noise) run under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import kmc_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          TYPED_ROWS   = 4;
    localparam int          DIRECT_ROWS  = 25;
    localparam logic [1:0]  KEY_ORDER [KEY_COUNT] = '{KEY_UP, KEY_DOWN, KEY_MENU};

    // Directed key levels, bits are {up, down, menu}
    localparam t_item DIRECTED_KEYS [DIRECT_ROWS] = '{
        3'b000, 3'b100, 3'b100, 3'b000, 3'b010, 3'b001, 3'b001, 3'b010, 3'b100,
        3'b001, 3'b010, 3'b100, 3'b001, 3'b010, 3'b110, 3'b000, 3'b001, 3'b100,
        3'b001, 3'b001, 3'b111, 3'b111, 3'b111, 3'b111, 3'b000
    };

    // Opening rows with hold_timeout 1 and setpoint_initial 32767: idle,
    // up press wraps the setpoint, up held steps again, release
    localparam t_result TYPED_RESULTS [TYPED_ROWS] = '{
        '{menu_mode: MODE_SP, setpoint: 16'sh7FFF, time_offset: 11'd0, control_on: 1'b1,
          entry_index: 2'd0, entry_field: FIELD_TEMP, entry_temp: 16'sd0,
          entry_minutes: 11'd0, event_valid: 1'b0, event_held: 1'b0, event_key: KEY_UP,
          program_saved: 1'b0},
        '{menu_mode: MODE_SP, setpoint: 16'sh8004, time_offset: 11'd0, control_on: 1'b1,
          entry_index: 2'd0, entry_field: FIELD_TEMP, entry_temp: 16'sd0,
          entry_minutes: 11'd0, event_valid: 1'b1, event_held: 1'b0, event_key: KEY_UP,
          program_saved: 1'b0},
        '{menu_mode: MODE_SP, setpoint: 16'sh8009, time_offset: 11'd0, control_on: 1'b1,
          entry_index: 2'd0, entry_field: FIELD_TEMP, entry_temp: 16'sd0,
          entry_minutes: 11'd0, event_valid: 1'b1, event_held: 1'b1, event_key: KEY_UP,
          program_saved: 1'b0},
        '{menu_mode: MODE_SP, setpoint: 16'sh8009, time_offset: 11'd0, control_on: 1'b1,
          entry_index: 2'd0, entry_field: FIELD_TEMP, entry_temp: 16'sd0,
          entry_minutes: 11'd0, event_valid: 1'b0, event_held: 1'b0, event_key: KEY_UP,
          program_saved: 1'b0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                push;
    logic                full;
    t_item               i_item;
    logic                empty;
    logic                pop;
    t_result             o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Panel model state
    logic [15:0]         hold_limit;
    logic [15:0]         key_cnt [KEY_COUNT];
    t_fifo_ent           pending_events [$];
    t_mode               panel_mode;
    logic [15:0]         sp_now;
    int                  offset_min;
    logic                ctl_on;
    int                  edit_idx;
    int                  edit_fld;
    logic [15:0]         prog_temp [PROGRAM_ENTRIES];
    int                  prog_min [PROGRAM_ENTRIES];

    t_result             panel_expected [$];
    t_result             oldest;
    int                  fail_count  = 0;
    int unsigned         cycle_count = 0;
    bit                  steady      = 1'b0;
    int                  pop_hold    = 0;

    keypad_menu_controller_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int wrap_day(int m);
        if (m < 0) m += int'(DAY_MINUTES);
        if (m >= int'(DAY_MINUTES)) m -= int'(DAY_MINUTES);
        return m;
    endfunction

    // Advance the panel by one tick and return the beat it should report
    function automatic t_result next_panel(t_item keys);
        logic [KEY_COUNT-1:0] levels;
        t_fifo_ent            ev;
        t_result              r;
        bit                   dropped;
        int                   dir;
        int                   e;
        levels  = {keys.key_menu, keys.key_down, keys.key_up};
        r       = '0;
        dropped = 1'b0;
        // Count keys; a full event queue drops the event and skips later keys
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (!dropped) begin
                key_cnt[k] = levels[k] ? key_cnt[k] + 16'd1 : 16'd0;
                if (key_cnt[k] == 16'd1) begin
                    if (pending_events.size() >= FIFO_DEPTH) dropped = 1'b1;
                    else pending_events.push_back(t_fifo_ent'{1'b0, KEY_ORDER[k]});
                end
                if (!dropped && key_cnt[k] > hold_limit) begin
                    key_cnt[k] = 16'd1;
                    if (pending_events.size() >= FIFO_DEPTH) dropped = 1'b1;
                    else pending_events.push_back(t_fifo_ent'{1'b1, KEY_ORDER[k]});
                end
            end
        end
        // Pop one event and run the menu
        if (pending_events.size() > 0) begin
            ev            = pending_events.pop_front();
            r.event_valid = 1'b1;
            r.event_held  = ev.held;
            r.event_key   = ev.key;
            dir = (ev.key == KEY_UP) ? 1 : (ev.key == KEY_DOWN) ? -1 : 0;
            case (panel_mode)
                MODE_SP: begin
                    if (dir > 0) sp_now = sp_now + SP_STEP;
                    else if (dir < 0) sp_now = sp_now - SP_STEP;
                    else if (ev.key == KEY_MENU && !ev.held) panel_mode = MODE_HOUR;
                end
                MODE_HOUR, MODE_MIN: begin
                    if (dir != 0) begin
                        offset_min = wrap_day(offset_min + dir *
                            ((panel_mode == MODE_HOUR) ? int'(STEP_HOUR) : int'(STEP_MINUTE)));
                    end else if (ev.key == KEY_MENU && !ev.held) begin
                        panel_mode = (panel_mode == MODE_HOUR) ? MODE_MIN : MODE_PROG;
                    end
                end
                MODE_PROG: begin
                    e = edit_idx % PROGRAM_ENTRIES;
                    if (dir != 0) begin
                        if (edit_fld == FIELD_TEMP)
                            prog_temp[e] = (dir > 0) ? prog_temp[e] + SP_STEP
                                                     : prog_temp[e] - SP_STEP;
                        else if (edit_fld == FIELD_HOUR)
                            prog_min[e] = wrap_day(prog_min[e] + dir * int'(STEP_HOUR));
                        else if (edit_fld == FIELD_TENMIN)
                            prog_min[e] = wrap_day(prog_min[e] + dir * int'(STEP_TENMIN));
                    end else if (ev.key == KEY_MENU) begin
                        if (ev.held) begin
                            // Long menu press stores the program and leaves
                            edit_idx        = 0;
                            edit_fld        = FIELD_TEMP;
                            panel_mode      = MODE_SP;
                            r.program_saved = 1'b1;
                        end else begin
                            edit_fld++;
                            if (edit_fld > FIELD_LAST) begin
                                edit_fld = FIELD_TEMP;
                                edit_idx++;
                            end
                            if (edit_idx >= PROGRAM_ENTRIES) begin
                                edit_idx        = 0;
                                panel_mode      = MODE_ONOFF;
                                r.program_saved = 1'b1;
                            end
                        end
                    end
                end
                MODE_ONOFF: begin
                    if (!ev.held) begin
                        if (dir > 0) ctl_on = 1'b1;
                        else if (dir < 0) ctl_on = 1'b0;
                        else if (ev.key == KEY_MENU) panel_mode = MODE_SP;
                    end
                end
                default: ;
            endcase
        end
        e               = edit_idx % PROGRAM_ENTRIES;
        r.menu_mode     = panel_mode;
        r.setpoint      = sp_now;
        r.time_offset   = 11'(offset_min);
        r.control_on    = ctl_on;
        r.entry_index   = 2'(edit_idx);
        r.entry_field   = 2'(edit_fld);
        r.entry_temp    = prog_temp[e];
        r.entry_minutes = 11'(prog_min[e]);
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Pop side: stall in short bursts, check each beat taken
    always @(negedge i_clk) begin
        if (!steady && pop_hold == 0 && $urandom_range(0, 7) == 0)
            pop_hold = $urandom_range(1, 5);
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (panel_expected.size() == 0) begin
                $error("result beat with no tick waiting for it");
                fail_count++;
            end else begin
                oldest = panel_expected.pop_front();
                check_field("menu_mode", oldest.menu_mode, o_result.menu_mode);
                check_field("setpoint", oldest.setpoint, o_result.setpoint);
                check_field("time_offset", oldest.time_offset, o_result.time_offset);
                check_field("control_on", oldest.control_on, o_result.control_on);
                check_field("entry_index", oldest.entry_index, o_result.entry_index);
                check_field("entry_field", oldest.entry_field, o_result.entry_field);
                check_field("entry_temp", oldest.entry_temp, o_result.entry_temp);
                check_field("entry_minutes", oldest.entry_minutes, o_result.entry_minutes);
                check_field("event_valid", oldest.event_valid, o_result.event_valid);
                check_field("event_held", oldest.event_held, o_result.event_held);
                check_field("event_key", oldest.event_key, o_result.event_key);
                check_field("program_saved", oldest.program_saved, o_result.program_saved);
            end
        end
    end

    // One register transfer, setup then access; called at a falling edge
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input int idx, input logic [15:0] want);
        logic [DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_W'(4 * idx), '0, rd);
        if (rd[15:0] !== want) begin
            $error("register %0d: expected %0h, got %0h", idx, want, rd[15:0]);
            fail_count++;
        end
    endtask

    task automatic set_register(input int idx, input logic [15:0] value);
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] data;
        data = (idx == int'(REG_SP_INITIAL)) ? DATA_W'(signed'(value)) : DATA_W'(value);
        apb_access(1'b1, ADDR_W'(4 * idx), data, rd);
        if (idx == int'(REG_HOLD_TIMEOUT)) hold_limit = value;
        else sp_now = value;
        check_register(idx, value);
    endtask

    // Stop pushing, drain all beats, let the block settle, then load both registers
    task automatic configure(input logic [15:0] hold, input logic [15:0] sp_init);
        push <= 1'b0;
        while (panel_expected.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        set_register(int'(REG_HOLD_TIMEOUT), hold);
        set_register(int'(REG_SP_INITIAL), sp_init);
    endtask

    // Push one tick with an optional gap ahead of it; called at a falling edge
    task automatic send_tick(input t_item keys, input bit use_typed, input t_result typed);
        t_result want;
        if (!steady && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= keys;
        do @(posedge i_clk); while (full);
        want = next_panel(keys);
        panel_expected.push_back(use_typed ? typed : want);
        @(negedge i_clk);
    endtask

    // Random key gestures: taps, long holds, chords, noise and quiet spells
    task automatic run_random(input int count);
        int    sent;
        int    pick;
        int    len;
        int    down_ticks;
        bit    noise;
        t_item tap;
        t_item keys;
        sent = 0;
        while (sent < count) begin
            pick  = $urandom_range(0, 99);
            noise = 1'b0;
            tap   = '0;
            case ($urandom_range(0, 5))
                0, 1:    tap.key_menu = 1'b1;
                2, 3:    tap.key_up   = 1'b1;
                default: tap.key_down = 1'b1;
            endcase
            if (pick < 55 || (pick < 70 && hold_limit > 16'd60)) begin
                down_ticks = $urandom_range(1, 2);
                len        = down_ticks + $urandom_range(1, 3);
            end else if (pick < 70) begin
                down_ticks = $urandom_range(int'(hold_limit), 3 * int'(hold_limit) + 3);
                len        = down_ticks + $urandom_range(1, 2);
            end else if (pick < 88) begin
                noise      = 1'b1;
                down_ticks = 0;
                len        = $urandom_range(1, 6);
            end else if (pick < 95) begin
                tap        = '1;
                down_ticks = $urandom_range(2, 10);
                len        = down_ticks + 2;
            end else begin
                down_ticks = 0;
                len        = $urandom_range(1, 4);
            end
            for (int t = 0; t < len; t++) begin
                if (noise) keys = t_item'(3'($urandom_range(0, 7)));
                else keys = (t < down_ticks) ? tap : t_item'('0);
                send_tick(keys, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_item  = '0;
        pop     = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        // Panel model after reset
        hold_limit = HOLD_TIMEOUT_RESET;
        sp_now     = SP_INITIAL_RESET;
        panel_mode = MODE_SP;
        offset_min = 0;
        ctl_on     = 1'b1;
        edit_idx   = 0;
        edit_fld   = FIELD_TEMP;
        for (int k = 0; k < KEY_COUNT; k++) key_cnt[k] = '0;
        for (int i = 0; i < PROGRAM_ENTRIES; i++) begin
            prog_temp[i] = '0;
            prog_min[i]  = 0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        check_register(int'(REG_HOLD_TIMEOUT), HOLD_TIMEOUT_RESET);
        check_register(int'(REG_SP_INITIAL), SP_INITIAL_RESET);

        // Directed walk through the setpoint, clock and program modes with the shortest hold time
        configure(16'd1, 16'h7FFF);
        for (int i = 0; i < DIRECT_ROWS; i++)
            send_tick(DIRECTED_KEYS[i], i < TYPED_ROWS, TYPED_RESULTS[i % TYPED_ROWS]);

        // Longest hold time, most negative setpoint
        configure(16'd65534, 16'h8000);
        run_random(250);

        // Default hold time, random setpoint
        configure(HOLD_TIMEOUT_RESET, 16'($urandom_range(0, 65535)));
        run_random(450);

        // Short hold times, then a closing stretch with no idling
        configure(16'($urandom_range(2, 8)), 16'($urandom_range(0, 65535)));
        run_random(300);
        steady = 1'b1;
        run_random(150);
        push <= 1'b0;

        while (panel_expected.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
